// ----- hdl/alist_pkg.sv -----
// ----------------------------------------------------------------------------
// alist_pkg
// Shared types, codes and constants of the array list block.
// ----------------------------------------------------------------------------
`default_nettype none

package alist_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 3;
	localparam int POS_W     = 5;
	localparam int CAP_W     = 5;
	localparam int STAT_W    = 2;
	localparam int FOUND_W   = 4;
	localparam int CNT_OUT_W = 5;
	localparam int APB_AW    = 3;

	localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
	localparam logic [APB_AW-1:0] ADDR_CAP  = 3'd0;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_LSEARCH = 3'd3;
	localparam logic [FUNC_W-1:0] FN_BSEARCH = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS   = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [FOUND_W-1:0]       found_index;
		logic signed [DATA_W-1:0] removed_value;
		logic [CNT_OUT_W-1:0]     count_now;
	} res_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_APPEND,
		WR_PLACE,
		WR_SHIFT
	} wr_op_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_CNT_M1,
		PTR_POS,
		PTR_ZERO,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		wr_op_t            wr_op;
		logic              dir_down;
		logic              rd_en;
		logic              rd_bs;
		ptr_op_t           ptr_op;
		logic              bs_init;
		logic              bs_step;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              finish;
		logic [STAT_W-1:0] res_status;
		logic              found_en;
		logic              found_bs;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              pos_le_cnt;
		logic              pos_lt_cnt;
		logic              cnt_zero;
		logic              ptr_at_pos;
		logic              ptr_at_last;
		logic              hit;
		logic              bs_more;
	} sts_t;

endpackage

`default_nettype wire

// ----- hdl/alist_ram.sv -----
// ----------------------------------------------------------------------------
// alist_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/alist_ctrl.sv -----
// ----------------------------------------------------------------------------
// alist_ctrl
// Sequencer of the array list: decodes an item and steps the datapath
// through shifts, scans and halving probes.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire alist_pkg::sts_t   sts,
	output alist_pkg::cmd_t        cmd,
	output logic                   busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SHUP,
		S_DRAIN_UP,
		S_PLACE,
		S_SHDN,
		S_DRAIN_DN,
		S_LIN,
		S_LIN_LAST,
		S_BRD,
		S_BCMP
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (sts.func)
					alist_pkg::FN_APPEND: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (sts.full) begin
							cmd.res_status = alist_pkg::ST_REJECT;
						end else begin
							cmd.wr_op      = alist_pkg::WR_APPEND;
							cmd.cnt_inc    = 1'b1;
							cmd.res_status = alist_pkg::ST_OK;
						end
					end
					alist_pkg::FN_INSERT: begin
						if (sts.full || !sts.pos_le_cnt) begin
							cmd.finish     = 1'b1;
							cmd.res_status = alist_pkg::ST_REJECT;
							state_d        = S_IDLE;
						end else if (sts.pos_lt_cnt) begin
							cmd.ptr_op = alist_pkg::PTR_CNT_M1;
							state_d    = S_SHUP;
						end else begin
							state_d = S_PLACE;
						end
					end
					alist_pkg::FN_DELETE: begin
						if (sts.pos_lt_cnt) begin
							cmd.ptr_op = alist_pkg::PTR_POS;
							state_d    = S_SHDN;
						end else begin
							cmd.finish     = 1'b1;
							cmd.res_status = alist_pkg::ST_REJECT;
							state_d        = S_IDLE;
						end
					end
					alist_pkg::FN_LSEARCH: begin
						if (sts.cnt_zero) begin
							cmd.finish     = 1'b1;
							cmd.res_status = alist_pkg::ST_MISS;
							state_d        = S_IDLE;
						end else begin
							cmd.ptr_op = alist_pkg::PTR_ZERO;
							state_d    = S_LIN;
						end
					end
					alist_pkg::FN_BSEARCH: begin
						if (sts.cnt_zero) begin
							cmd.finish     = 1'b1;
							cmd.res_status = alist_pkg::ST_MISS;
							state_d        = S_IDLE;
						end else begin
							cmd.bs_init = 1'b1;
							state_d     = S_BRD;
						end
					end
					default: begin
						cmd.finish     = 1'b1;
						cmd.res_status = alist_pkg::ST_REJECT;
						state_d        = S_IDLE;
					end
				endcase
			end
			// read downwards from the top entry, write each one a place higher
			S_SHUP: begin
				cmd.rd_en  = 1'b1;
				cmd.wr_op  = alist_pkg::WR_SHIFT;
				cmd.ptr_op = alist_pkg::PTR_DEC;
				if (sts.ptr_at_pos) begin
					state_d = S_DRAIN_UP;
				end
			end
			S_DRAIN_UP: begin
				cmd.wr_op = alist_pkg::WR_SHIFT;
				state_d   = S_PLACE;
			end
			S_PLACE: begin
				cmd.wr_op      = alist_pkg::WR_PLACE;
				cmd.cnt_inc    = 1'b1;
				cmd.finish     = 1'b1;
				cmd.res_status = alist_pkg::ST_OK;
				state_d        = S_IDLE;
			end
			// first read is the removed entry, the rest move a place lower
			S_SHDN: begin
				cmd.rd_en    = 1'b1;
				cmd.wr_op    = alist_pkg::WR_SHIFT;
				cmd.dir_down = 1'b1;
				cmd.ptr_op   = alist_pkg::PTR_INC;
				if (sts.ptr_at_last) begin
					state_d = S_DRAIN_DN;
				end
			end
			S_DRAIN_DN: begin
				cmd.wr_op      = alist_pkg::WR_SHIFT;
				cmd.dir_down   = 1'b1;
				cmd.cnt_dec    = 1'b1;
				cmd.finish     = 1'b1;
				cmd.res_status = alist_pkg::ST_OK;
				state_d        = S_IDLE;
			end
			S_LIN: begin
				if (sts.hit) begin
					cmd.finish     = 1'b1;
					cmd.found_en   = 1'b1;
					cmd.res_status = alist_pkg::ST_OK;
					state_d        = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.ptr_op = alist_pkg::PTR_INC;
					if (sts.ptr_at_last) begin
						state_d = S_LIN_LAST;
					end
				end
			end
			S_LIN_LAST: begin
				cmd.finish     = 1'b1;
				cmd.found_en   = sts.hit;
				cmd.res_status = sts.hit ? alist_pkg::ST_OK : alist_pkg::ST_MISS;
				state_d        = S_IDLE;
			end
			S_BRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_bs = 1'b1;
				state_d   = S_BCMP;
			end
			S_BCMP: begin
				if (sts.hit) begin
					cmd.finish     = 1'b1;
					cmd.found_en   = 1'b1;
					cmd.found_bs   = 1'b1;
					cmd.res_status = alist_pkg::ST_OK;
					state_d        = S_IDLE;
				end else begin
					cmd.bs_step = 1'b1;
					if (sts.bs_more) begin
						state_d = S_BRD;
					end else begin
						cmd.finish     = 1'b1;
						cmd.res_status = alist_pkg::ST_MISS;
						state_d        = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/alist_dp.sv -----
// ----------------------------------------------------------------------------
// alist_dp
// Datapath of the array list: entry store, count, scan pointer, search
// bounds and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_dp #(
	parameter int DEPTH = alist_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire alist_pkg::req_t               req,
	input  wire logic [alist_pkg::CAP_W-1:0]   capacity,
	input  wire alist_pkg::cmd_t               cmd,
	output alist_pkg::sts_t                    sts,
	output logic                               done,
	output alist_pkg::res_t                    result
);

	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int PW     = alist_pkg::POS_W;
	localparam int KW     = alist_pkg::CAP_W;
	localparam int DW     = alist_pkg::DATA_W;
	localparam int FW     = alist_pkg::FOUND_W;
	localparam int OW     = alist_pkg::CNT_OUT_W;
	localparam int CMP_W0 = (CW > PW) ? CW : PW;
	localparam int CMP_W  = (CMP_W0 > KW) ? CMP_W0 : KW;

	logic [alist_pkg::FUNC_W-1:0] func_q;
	logic [PW-1:0]                pos_q;
	logic [DW-1:0]                val_q;
	logic [DW-1:0]                key_q;
	logic [DW-1:0]                removed_q, removed_d;
	logic [CW-1:0]                cnt_q, cnt_d, cnt_m1;
	logic [AW-1:0]                rptr_q;
	logic [CW-1:0]                lo_q, hx_q;
	logic [CW:0]                  mid_sum;
	logic [CW-1:0]                mid_full;
	logic [AW-1:0]                mid_a, mid_s1;
	logic [CW-1:0]                mid_ext, mid_p1;
	logic                         rd_v_s1;
	logic [AW-1:0]                rd_addr_s1;
	logic [CMP_W-1:0]             posx, cntx, capx;
	logic [AW-1:0]                pos_a;
	logic                         key_less, eq, capture;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [DW-1:0]                ram_wdata, ram_rdata;
	logic                         done_q;
	alist_pkg::res_t              res_q;
	logic [AW-1:0]                found_a;

	assign posx   = CMP_W'(pos_q);
	assign cntx   = CMP_W'(cnt_q);
	assign capx   = CMP_W'(capacity);
	assign pos_a  = posx[AW-1:0];
	assign cnt_m1 = cnt_q - CW'(1);

	// bounds kept as lo and one past hi, so both stay unsigned
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hx_q} - (CW + 1)'(1);
	assign mid_full = mid_sum[CW:1];
	assign mid_a    = mid_full[AW-1:0];
	assign mid_ext  = CW'(mid_s1);
	assign mid_p1   = mid_ext + CW'(1);

	assign eq       = (ram_rdata == key_q);
	assign key_less = ($signed(key_q) < $signed(ram_rdata));

	assign sts.func        = func_q;
	assign sts.full        = (cntx >= capx) || (cnt_q >= CW'(DEPTH));
	assign sts.pos_le_cnt  = (posx <= cntx);
	assign sts.pos_lt_cnt  = (posx < cntx);
	assign sts.cnt_zero    = (cnt_q == '0);
	assign sts.ptr_at_pos  = (rptr_q == pos_a);
	assign sts.ptr_at_last = (rptr_q == cnt_m1[AW-1:0]);
	assign sts.hit         = rd_v_s1 && eq;
	assign sts.bs_more     = key_less ? (lo_q < mid_ext) : (mid_p1 < hx_q);

	// the read of the deleted position returns the removed entry
	assign capture = (cmd.wr_op == alist_pkg::WR_SHIFT) && cmd.dir_down && rd_v_s1
		&& (rd_addr_s1 == pos_a);
	assign removed_d = capture ? ram_rdata : removed_q;

	assign ram_raddr = cmd.rd_bs ? mid_a : rptr_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_a;
		ram_wdata = val_q;
		case (cmd.wr_op)
			alist_pkg::WR_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
			end
			alist_pkg::WR_PLACE: begin
				ram_we = 1'b1;
			end
			alist_pkg::WR_SHIFT: begin
				ram_we    = rd_v_s1 && !capture;
				ram_waddr = cmd.dir_down ? (rd_addr_s1 - AW'(1)) : (rd_addr_s1 + AW'(1));
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.cnt_inc) begin
			cnt_d = cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_d = cnt_q - CW'(1);
		end
	end

	assign found_a = cmd.found_bs ? mid_s1 : rd_addr_s1;

	alist_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			rd_v_s1 <= cmd.rd_en;
			done_q  <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= req.func;
			pos_q     <= req.position;
			val_q     <= req.value;
			key_q     <= req.key;
			removed_q <= '0;
		end else if (capture) begin
			removed_q <= ram_rdata;
		end
		case (cmd.ptr_op)
			alist_pkg::PTR_CNT_M1: rptr_q <= cnt_m1[AW-1:0];
			alist_pkg::PTR_POS:    rptr_q <= pos_a;
			alist_pkg::PTR_ZERO:   rptr_q <= '0;
			alist_pkg::PTR_INC:    rptr_q <= rptr_q + AW'(1);
			alist_pkg::PTR_DEC:    rptr_q <= rptr_q - AW'(1);
			default:               rptr_q <= rptr_q;
		endcase
		if (cmd.rd_en) begin
			rd_addr_s1 <= ram_raddr;
		end
		if (cmd.rd_bs) begin
			mid_s1 <= mid_a;
		end
		if (cmd.bs_init) begin
			lo_q <= '0;
			hx_q <= cnt_q;
		end else if (cmd.bs_step) begin
			if (key_less) begin
				hx_q <= mid_ext;
			end else begin
				lo_q <= mid_p1;
			end
		end
		if (cmd.finish) begin
			res_q.status        <= cmd.res_status;
			res_q.found_index   <= (cmd.found_en && (cmd.res_status == alist_pkg::ST_OK))
				? FW'(found_a) : '0;
			res_q.removed_value <= removed_d;
			res_q.count_now     <= OW'(cnt_d);
		end
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("list count above store depth");

	a_cnt_moves_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> done_q)
		else $error("count changed without a result");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (res_q.status != alist_pkg::ST_OK)) |-> (res_q.found_index == '0))
		else $error("found index set on a failed item");
`endif

endmodule

`default_nettype wire

// ----- hdl/array_list_insert_delete_search_top.sv -----
// The single read port of the entry store sets the pace: entries are moved or
// compared one at a time, and a new item is not taken while busy. The next item
// is taken in the cycle the result shows. Reset clears the count and sets
// capacity to 16; the store is not cleared.
// ----------------------------------------------------------------------------
// array_list_insert_delete_search_top
// Packed list of signed entries with append, insert, delete and searches.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_insert_delete_search_top #(
	parameter int DEPTH = alist_pkg::DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire alist_pkg::req_t                req,
	output logic                                done,
	output alist_pkg::res_t                     result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [alist_pkg::APB_AW-1:0]   paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready
);

	localparam int KW = alist_pkg::CAP_W;

	logic [KW-1:0]   cap_q;
	alist_pkg::cmd_t cmd;
	alist_pkg::sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= alist_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && (paddr == alist_pkg::ADDR_CAP)) begin
			cap_q <= pwdata[KW-1:0];
		end
	end

	assign prdata = (paddr == alist_pkg::ADDR_CAP) ? 32'(cap_q) : '0;

	alist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	alist_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.capacity (cap_q),
		.cmd      (cmd),
		.sts      (sts),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the array list: a directed table of operations, then
// random phases over several capacities, checked against a built-in list model.
// ----------------------------------------------------------------------------

module tb;
	import alist_pkg::*;

	localparam int LIST_DEPTH     = DEPTH_DEF;
	localparam int RAND_PER_PHASE = 72;
	localparam int PHASES         = 9;
	localparam int TAIL_CYCLES    = 40;

	// operation codes the block does not define
	localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

	localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct {
		req_t item;
		bit   typed;
		res_t want;
	} step_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                req;
	logic                done;
	res_t                result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// mirror of the list held by the block
	logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
	int                       list_count;
	int                       list_cap;

	res_t      pending_results[$];
	step_row_t rows[$];
	int        errors;
	int        cap_plan [PHASES] = '{31, 3, 0, 16, 1, 17, 8, 2, 16};
	int        idle_plan [4] = '{0, 84, 0, 33};

	array_list_insert_delete_search_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// apply one operation to the mirror and return the result it gives
	function automatic res_t list_apply(input req_t r);
		res_t o;
		int   lim;
		int   pos;
		int   lo;
		int   hi;
		int   mid;
		o = '0;
		o.status = ST_REJECT;
		lim = (list_cap < LIST_DEPTH) ? list_cap : LIST_DEPTH;
		pos = int'(r.position);
		case (r.func)
		FN_APPEND: begin
			if (list_count < lim) begin
				list_mem[list_count] = r.value;
				list_count++;
				o.status = ST_OK;
			end
		end
		FN_INSERT: begin
			if (pos <= list_count && list_count < lim) begin
				for (int i = list_count; i > pos; i--)
					list_mem[i] = list_mem[i-1];
				list_mem[pos] = r.value;
				list_count++;
				o.status = ST_OK;
			end
		end
		FN_DELETE: begin
			if (pos < list_count) begin
				o.removed_value = list_mem[pos];
				for (int i = pos; i + 1 < list_count; i++)
					list_mem[i] = list_mem[i+1];
				list_count--;
				o.status = ST_OK;
			end
		end
		FN_LSEARCH: begin
			o.status = ST_MISS;
			for (int i = 0; i < list_count && o.status != ST_OK; i++) begin
				if (list_mem[i] == r.key) begin
					o.status = ST_OK;
					o.found_index = FOUND_W'(i);
				end
			end
		end
		FN_BSEARCH: begin
			o.status = ST_MISS;
			lo = 0;
			hi = list_count - 1;
			while (lo <= hi && o.status != ST_OK) begin
				mid = (lo + hi) / 2;
				if (list_mem[mid] == r.key) begin
					o.status = ST_OK;
					o.found_index = FOUND_W'(mid);
				end else if ($signed(r.key) < $signed(list_mem[mid])) begin
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
		end
		default: begin
		end
		endcase
		o.count_now = CNT_OUT_W'(list_count);
		return o;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return WORD_MIN;
		if (roll == 1)
			return WORD_MAX;
		if (roll < 6)
			return DATA_W'($urandom_range(40)) - 20;
		return $urandom;
	endfunction

	// build one random operation; keep_sorted holds the list in ascending order
	function automatic req_t random_item(input bit keep_sorted);
		req_t r;
		int   roll;
		int   below;
		bit   ordered;
		roll = $urandom_range(99);
		r.func = FN_LSEARCH;
		r.position = POS_W'($urandom_range(31));
		r.value = pick_word();
		r.key = pick_word();
		if (list_count > 0 && $urandom_range(1))
			r.key = list_mem[$urandom_range(list_count - 1)];
		ordered = 1'b1;
		for (int i = 1; i < list_count; i++)
			if (list_mem[i] < list_mem[i-1])
				ordered = 1'b0;
		if (roll < 4) begin
			r.func = FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
		end else if (keep_sorted && !ordered) begin
			// drain from the front until the order is restored
			r.func = FN_DELETE;
			r.position = '0;
		end else if (roll < 24) begin
			r.func = FN_APPEND;
			if (keep_sorted && list_count > 0 && r.value < list_mem[list_count-1])
				r.value = list_mem[list_count-1];
		end else if (roll < 48) begin
			r.func = FN_INSERT;
			if (keep_sorted) begin
				below = 0;
				for (int i = 0; i < list_count; i++)
					if (list_mem[i] < r.value)
						below++;
				r.position = POS_W'(below);
			end else if ($urandom_range(4) != 0) begin
				r.position = POS_W'($urandom_range(list_count));
			end
		end else if (roll < 68) begin
			r.func = FN_DELETE;
			if (list_count > 0 && $urandom_range(4) != 0)
				r.position = POS_W'($urandom_range(list_count - 1));
		end else if (roll >= 84) begin
			r.func = FN_BSEARCH;
		end
		return r;
	endfunction

	function automatic void add_row(input logic [FUNC_W-1:0] f, input int p,
			input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] k,
			input bit typed, input logic [STAT_W-1:0] st, input int fi,
			input logic signed [DATA_W-1:0] rm, input int cn);
		step_row_t s;
		s.item.func = f;
		s.item.position = POS_W'(p);
		s.item.value = v;
		s.item.key = k;
		s.typed = typed;
		s.want.status = st;
		s.want.found_index = FOUND_W'(fi);
		s.want.removed_value = rm;
		s.want.count_now = CNT_OUT_W'(cn);
		rows.push_back(s);
	endfunction

	// hold start until the item is taken, then log what it must return
	task automatic issue(input req_t r, input bit typed, input res_t want);
		res_t predicted;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predicted = list_apply(r);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(input int cap);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_CAP;
		pwdata <= 32'(cap);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		list_cap = cap % 32;
		@(negedge clk);
		// read it back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CAP_W-1:0] !== CAP_W'(cap)) begin
			$display("%0t: capacity read expected %0d got %0d", $time, cap,
				prdata[CAP_W-1:0]);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none pending, got %h", $time, result);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, result.status);
					errors++;
				end
				if (result.found_index !== want.found_index) begin
					$display("%0t: found_index expected %0d got %0d", $time,
						want.found_index, result.found_index);
					errors++;
				end
				if (result.removed_value !== want.removed_value) begin
					$display("%0t: removed_value expected %h got %h", $time,
						want.removed_value, result.removed_value);
					errors++;
				end
				if (result.count_now !== want.count_now) begin
					$display("%0t: count_now expected %0d got %0d", $time,
						want.count_now, result.count_now);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		list_count = 0;
		list_cap = int'(CAP_RESET);

		// empty list: searches miss, delete and a far insert are rejected
		add_row(FN_LSEARCH, 0, 0, 0, 1, ST_MISS, 0, 0, 0);
		add_row(FN_BSEARCH, 0, 0, WORD_MAX, 1, ST_MISS, 0, 0, 0);
		add_row(FN_DELETE, 0, 0, 0, 1, ST_REJECT, 0, 0, 0);
		add_row(FN_INSERT, 1, 5, 0, 1, ST_REJECT, 0, 0, 0);
		add_row(FN_APPEND, 0, WORD_MIN, 0, 1, ST_OK, 0, 0, 1);
		add_row(FN_APPEND, 31, WORD_MAX, WORD_MIN, 1, ST_OK, 0, 0, 2);
		add_row(FN_INSERT, 1, 0, 0, 1, ST_OK, 0, 0, 3);
		add_row(FN_INSERT, 1, -5, -1, 0, ST_OK, 0, 0, 0);
		add_row(FN_BSEARCH, 0, 0, WORD_MAX, 0, ST_OK, 0, 0, 0);
		add_row(FN_BSEARCH, 0, 0, WORD_MIN, 0, ST_OK, 0, 0, 0);
		add_row(FN_BSEARCH, 0, 0, 1, 0, ST_OK, 0, 0, 0);
		add_row(FN_LSEARCH, 0, 0, 0, 0, ST_OK, 0, 0, 0);
		add_row(FN_LSEARCH, 0, 0, -1, 0, ST_OK, 0, 0, 0);
		add_row(FN_SPARE_LO, 2, 1, 1, 1, ST_REJECT, 0, 0, 4);
		add_row(FN_SPARE_MID, 0, 0, 0, 1, ST_REJECT, 0, 0, 4);
		add_row(FN_SPARE_HI, 31, -1, -1, 1, ST_REJECT, 0, 0, 4);
		add_row(FN_DELETE, 31, 0, 0, 1, ST_REJECT, 0, 0, 4);
		add_row(FN_DELETE, 4, 0, 0, 1, ST_REJECT, 0, 0, 4);
		add_row(FN_DELETE, 3, 0, 0, 1, ST_OK, 0, WORD_MAX, 3);
		add_row(FN_DELETE, 0, 0, 0, 1, ST_OK, 0, WORD_MIN, 2);
		add_row(FN_INSERT, 2, 123, 0, 0, ST_OK, 0, 0, 0);
		add_row(FN_LSEARCH, 0, 0, 123, 0, ST_OK, 0, 0, 0);
		add_row(FN_INSERT, 16, 7, 0, 1, ST_REJECT, 0, 0, 3);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i])
			issue(rows[i].item, rows[i].typed, rows[i].want);

		// one phase keeps no order so bad positions and unsorted binary search show up
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(cap_plan[ph]);
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (ph == 1 && n == RAND_PER_PHASE / 2)
					settle();
				idle_gap(idle_plan[ph % 4]);
				issue(random_item(ph != 6), 1'b0, '0);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("tb NOT OK");
		$finish;
	end

endmodule
